// ===== rtl/free_list_block_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the free list block allocator
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FLA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FLA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fla_pkg.sv =====
// ----------------------------------------------------------------------------
// Free list block allocator package
// Shared widths, codes and types of the allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

    localparam int ARENA_BYTES = 4194304;
    localparam int NODES       = 64;
    localparam int NIDX_W      = $clog2(NODES);
    localparam int LINK_W      = NIDX_W + 1;
    localparam int STEP_W      = $clog2(NODES + 1);
    localparam int ADDR_W      = 22;
    localparam int NEED_W      = 23;
    localparam int BUMP_W      = 23;
    localparam int END_W       = 24;

    localparam logic [LINK_W-1:0] NIL       = '1;
    localparam logic [NEED_W-1:0] NEED_MASK = ~NEED_W'(7);
    localparam logic [ADDR_W-1:0] HDR_BYTES = ADDR_W'(16);
    localparam logic [ADDR_W-1:0] MIN_SPLIT = ADDR_W'(24);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_NEXT  = 2'd1;
    localparam logic [1:0] MODE_BEST  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] bytes;
        logic              used;
        logic [LINK_W-1:0] link;
    } t_node;

    typedef struct packed {
        logic fits;
        logic better;
        logic addr_hit;
    } t_fit;

endpackage

// ===== rtl/fla_if.sv =====
// ----------------------------------------------------------------------------
// Free list block allocator channels
// Request, response and configuration channels with valid and ready.
// ----------------------------------------------------------------------------
interface fla_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [21:0] req_bytes;
    logic [21:0] free_addr;
    modport source (output valid, cmd, req_bytes, free_addr, input ready);
    modport sink (input valid, cmd, req_bytes, free_addr, output ready);
endinterface

interface fla_rsp_if;
    logic        valid;
    logic        ready;
    logic [21:0] result_addr;
    logic [1:0]  status;
    modport source (output valid, result_addr, status, input ready);
    modport sink (input valid, result_addr, status, output ready);
endinterface

interface fla_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/fla_node_ram.sv =====
// ----------------------------------------------------------------------------
// Node table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fla_node_ram (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [fla_pkg::NIDX_W-1:0]   i_waddr,
    input  fla_pkg::t_node               i_wdata,
    input  logic [fla_pkg::NIDX_W-1:0]   i_raddr,
    output fla_pkg::t_node               o_rdata
);
    import fla_pkg::*;

    t_node r_mem [NODES];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fla_fit_unit.sv =====
// ----------------------------------------------------------------------------
// Fit and match unit
// Compares one node against the request, the best so far and a payload address.
// ----------------------------------------------------------------------------
module fla_fit_unit (
    input  fla_pkg::t_node               i_node,
    input  logic [fla_pkg::NEED_W-1:0]   i_need,
    input  logic [fla_pkg::ADDR_W-1:0]   i_addr,
    input  logic [fla_pkg::ADDR_W-1:0]   i_best_bytes,
    input  logic                         i_best_vld,
    output fla_pkg::t_fit                o_fit
);
    import fla_pkg::*;

    logic [NEED_W-1:0] payload;

    always_comb begin
        payload        = NEED_W'(i_node.offset) + NEED_W'(HDR_BYTES);
        o_fit.fits     = !i_node.used && (NEED_W'(i_node.bytes) >= i_need);
        // Strictly smaller keeps the earliest block of equal slack.
        o_fit.better   = o_fit.fits && (!i_best_vld || (i_node.bytes < i_best_bytes));
        o_fit.addr_hit = (payload == NEED_W'(i_addr));
    end

endmodule

// ===== rtl/free_list_block_allocator.sv =====
// Sequence: each node walked takes an address state and a data state (the node table read is
// registered), up to NODES nodes per pass, two passes for next fit, then a scan of up to NODES
// entries for a spare node and the write states.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous active low, clears the list pointers, valid bits, arena end,
// result valid flag and sets the search mode to best fit; no clearing pass.
// ----------------------------------------------------------------------------
// Free list block allocator
// Sequencer that walks the linked node table through one shared fit unit.
// ----------------------------------------------------------------------------
`include "free_list_block_allocator_assert.svh"

module free_list_block_allocator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fla_req_if.sink   i_req,
    fla_rsp_if.source o_rsp,
    fla_cfg_if.sink   i_cfg
);
    import fla_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WADDR   = 4'd1;
    localparam logic [3:0] S_WDATA   = 4'd2;
    localparam logic [3:0] S_PEND    = 4'd3;
    localparam logic [3:0] S_FOUND   = 4'd4;
    localparam logic [3:0] S_SCAN    = 4'd5;
    localparam logic [3:0] S_SPLIT   = 4'd6;
    localparam logic [3:0] S_WRITE_B = 4'd7;
    localparam logic [3:0] S_GROW    = 4'd8;
    localparam logic [3:0] S_TAIL_RD = 4'd9;
    localparam logic [3:0] S_TAIL_WR = 4'd10;
    localparam logic [3:0] S_NX_RD   = 4'd11;
    localparam logic [3:0] S_NX_CHK  = 4'd12;
    localparam logic [3:0] S_FREE_WR = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    logic [3:0]        r_state, n_state;
    logic              r_cmd, n_cmd;
    logic [NEED_W-1:0] r_need, n_need;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_stop, n_stop;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic              r_pass, n_pass;
    logic              r_best_vld, n_best_vld;
    logic [LINK_W-1:0] r_b, n_b;
    t_node             r_bw, n_bw;
    logic [NIDX_W-1:0] r_spare, n_spare;
    logic              r_spare_ok, n_spare_ok;
    logic              r_split, n_split;
    logic [NIDX_W-1:0] r_scan, n_scan;
    logic [LINK_W-1:0] r_head, n_head;
    logic [LINK_W-1:0] r_tail, n_tail;
    logic [LINK_W-1:0] r_ss, n_ss;
    logic [BUMP_W-1:0] r_bump, n_bump;
    logic [NODES-1:0]  r_valid, n_valid;
    logic [1:0]        r_mode, n_mode;
    logic [ADDR_W-1:0] r_fin_addr, n_fin_addr;
    logic [1:0]        r_fin_status, n_fin_status;
    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [1:0]        r_res_status, n_res_status;

    logic              ram_we;
    logic [NIDX_W-1:0] ram_waddr;
    t_node             ram_wdata;
    logic [NIDX_W-1:0] ram_raddr;
    t_node             ram_rdata;
    t_fit              fit;
    logic              req_acc;
    logic              best_mode;
    logic [ADDR_W-1:0] rest;
    logic [END_W-1:0]  grow_end;

    function automatic logic idx_ok(input logic [LINK_W-1:0] idx, input logic [NODES-1:0] vld);
        logic ok;
        ok = 1'b0;
        if (idx < LINK_W'(NODES)) begin
            ok = vld[idx[NIDX_W-1:0]];
        end
        return ok;
    endfunction

    fla_node_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fla_fit_unit u_fit (
        .i_node       (ram_rdata),
        .i_need       (r_need),
        .i_addr       (r_addr),
        .i_best_bytes (r_bw.bytes),
        .i_best_vld   (r_best_vld),
        .o_fit        (fit)
    );

    assign i_req.ready       = (r_state == S_IDLE);
    assign req_acc           = i_req.valid && i_req.ready;
    // The mode only changes while no transaction is in progress or being taken.
    assign i_cfg.ready       = (r_state == S_IDLE) && !i_req.valid;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_addr = r_res_addr;
    assign o_rsp.status      = r_res_status;

    // Modes two and three both select best fit.
    assign best_mode = r_mode[1];
    assign rest      = r_bw.bytes - r_need[ADDR_W-1:0];
    assign grow_end  = END_W'(r_bump) + END_W'(r_need) + END_W'(HDR_BYTES);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_need       = r_need;
        n_addr       = r_addr;
        n_cur        = r_cur;
        n_stop       = r_stop;
        n_steps      = r_steps;
        n_pass       = r_pass;
        n_best_vld   = r_best_vld;
        n_b          = r_b;
        n_bw         = r_bw;
        n_spare      = r_spare;
        n_spare_ok   = r_spare_ok;
        n_split      = r_split;
        n_scan       = r_scan;
        n_head       = r_head;
        n_tail       = r_tail;
        n_ss         = r_ss;
        n_bump       = r_bump;
        n_valid      = r_valid;
        n_mode       = r_mode;
        n_fin_addr   = r_fin_addr;
        n_fin_status = r_fin_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        ram_we       = 1'b0;
        ram_waddr    = r_b[NIDX_W-1:0];
        ram_wdata    = r_bw;
        ram_raddr    = r_cur[NIDX_W-1:0];

        if (i_cfg.valid && i_cfg.ready) begin
            n_mode = i_cfg.data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_cmd      = i_req.cmd;
                    n_need     = (NEED_W'(i_req.req_bytes) + NEED_W'(7)) & NEED_MASK;
                    n_addr     = i_req.free_addr;
                    n_steps    = '0;
                    n_best_vld = 1'b0;
                    n_pass     = 1'b0;
                    n_stop     = NIL;
                    n_cur      = (i_req.cmd == CMD_ALLOC && r_mode == MODE_NEXT) ? r_ss : r_head;
                    n_state    = S_WADDR;
                end
            end
            S_WADDR: begin
                if ((r_cur != r_stop) && idx_ok(r_cur, r_valid) &&
                    (r_steps < STEP_W'(NODES))) begin
                    n_state = S_WDATA;
                end else begin
                    n_state = S_PEND;
                end
            end
            S_WDATA: begin
                n_cur   = ram_rdata.link;
                n_steps = r_steps + STEP_W'(1);
                n_state = S_WADDR;
                if (r_cmd == CMD_FREE) begin
                    if (fit.addr_hit) begin
                        n_b     = r_cur;
                        n_bw    = ram_rdata;
                        n_state = S_NX_RD;
                    end
                end else if (best_mode) begin
                    if (fit.better) begin
                        n_b        = r_cur;
                        n_bw       = ram_rdata;
                        n_best_vld = 1'b1;
                    end
                end else if (fit.fits) begin
                    n_b     = r_cur;
                    n_bw    = ram_rdata;
                    n_state = S_FOUND;
                end
            end
            S_PEND: begin
                if (r_cmd == CMD_FREE) begin
                    n_fin_addr   = '0;
                    n_fin_status = ST_UNKNOWN;
                    n_state      = S_DONE;
                end else if (best_mode && r_best_vld) begin
                    n_state = S_FOUND;
                end else if (r_mode == MODE_NEXT && !r_pass) begin
                    // Second pass wraps round from the head up to the start point.
                    n_pass  = 1'b1;
                    n_cur   = r_head;
                    n_stop  = r_ss;
                    n_steps = '0;
                    n_state = S_WADDR;
                end else begin
                    n_split = 1'b0;
                    n_scan  = '0;
                    n_state = S_SCAN;
                end
            end
            S_FOUND: begin
                if (r_mode == MODE_NEXT) begin
                    n_ss = r_b;
                end
                if (rest >= MIN_SPLIT) begin
                    n_split = 1'b1;
                    n_scan  = '0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_WRITE_B;
                end
            end
            S_SCAN: begin
                if (!r_valid[r_scan]) begin
                    n_spare    = r_scan;
                    n_spare_ok = 1'b1;
                    n_state    = r_split ? S_SPLIT : S_GROW;
                end else if (r_scan == NIDX_W'(NODES - 1)) begin
                    n_spare_ok = 1'b0;
                    n_state    = r_split ? S_SPLIT : S_GROW;
                end else begin
                    n_scan = r_scan + NIDX_W'(1);
                end
            end
            S_SPLIT: begin
                if (r_spare_ok) begin
                    ram_we           = 1'b1;
                    ram_waddr        = r_spare;
                    ram_wdata.offset = r_bw.offset + HDR_BYTES + r_need[ADDR_W-1:0];
                    ram_wdata.bytes  = rest - HDR_BYTES;
                    ram_wdata.used   = 1'b0;
                    ram_wdata.link   = r_bw.link;
                    n_valid[r_spare] = 1'b1;
                    n_bw.link        = LINK_W'(r_spare);
                    n_bw.bytes       = r_need[ADDR_W-1:0];
                    if (r_tail == r_b) begin
                        n_tail = LINK_W'(r_spare);
                    end
                end
                n_state = S_WRITE_B;
            end
            S_WRITE_B: begin
                ram_we         = 1'b1;
                ram_wdata.used = 1'b1;
                n_fin_addr     = r_bw.offset + HDR_BYTES;
                n_fin_status   = ST_OK;
                n_state        = S_DONE;
            end
            S_GROW: begin
                if (!r_spare_ok || (grow_end >= END_W'(ARENA_BYTES))) begin
                    n_fin_addr   = '0;
                    n_fin_status = ST_NOSPACE;
                    n_state      = S_DONE;
                end else begin
                    ram_we           = 1'b1;
                    ram_waddr        = r_spare;
                    ram_wdata.offset = r_bump[ADDR_W-1:0];
                    ram_wdata.bytes  = r_need[ADDR_W-1:0];
                    ram_wdata.used   = 1'b1;
                    ram_wdata.link   = NIL;
                    n_valid[r_spare] = 1'b1;
                    n_bump           = grow_end[BUMP_W-1:0];
                    n_fin_addr       = r_bump[ADDR_W-1:0] + HDR_BYTES;
                    n_fin_status     = ST_OK;
                    if (r_head == NIL) begin
                        n_head = LINK_W'(r_spare);
                        n_ss   = LINK_W'(r_spare);
                    end
                    n_tail = LINK_W'(r_spare);
                    n_b    = r_tail;
                    n_state = idx_ok(r_tail, r_valid) ? S_TAIL_RD : S_DONE;
                end
            end
            S_TAIL_RD: begin
                ram_raddr = r_b[NIDX_W-1:0];
                n_state   = S_TAIL_WR;
            end
            S_TAIL_WR: begin
                ram_we         = 1'b1;
                ram_wdata      = ram_rdata;
                ram_wdata.link = LINK_W'(r_spare);
                n_state        = S_DONE;
            end
            S_NX_RD: begin
                ram_raddr = r_bw.link[NIDX_W-1:0];
                n_state   = idx_ok(r_bw.link, r_valid) ? S_NX_CHK : S_FREE_WR;
            end
            S_NX_CHK: begin
                if (!ram_rdata.used) begin
                    n_bw.bytes = r_bw.bytes + ram_rdata.bytes + HDR_BYTES;
                    n_bw.link  = ram_rdata.link;
                    n_valid[r_bw.link[NIDX_W-1:0]] = 1'b0;
                    if (r_tail == r_bw.link) begin
                        n_tail = r_b;
                    end
                    if (r_ss == r_bw.link) begin
                        n_ss = r_b;
                    end
                end
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                ram_we         = 1'b1;
                ram_wdata.used = 1'b0;
                n_fin_addr     = '0;
                n_fin_status   = ST_OK;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_res_addr   = r_fin_addr;
                    n_res_status = r_fin_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_ss        <= NIL;
            r_bump      <= '0;
            r_valid     <= '0;
            r_mode      <= MODE_BEST;
            r_out_valid <= 1'b0;
            r_steps     <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_ss        <= n_ss;
            r_bump      <= n_bump;
            r_valid     <= n_valid;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
            r_steps     <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_need       <= n_need;
        r_addr       <= n_addr;
        r_cur        <= n_cur;
        r_stop       <= n_stop;
        r_pass       <= n_pass;
        r_best_vld   <= n_best_vld;
        r_b          <= n_b;
        r_bw         <= n_bw;
        r_spare      <= n_spare;
        r_spare_ok   <= n_spare_ok;
        r_split      <= n_split;
        r_scan       <= n_scan;
        r_fin_addr   <= n_fin_addr;
        r_fin_status <= n_fin_status;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
    end

    `FLA_ASSERT_IMP(a_steps_bound, 1'b1, r_steps <= STEP_W'(NODES), "walk ran past the table size")
    `FLA_ASSERT_IMP(a_fail_zero, o_rsp.valid && o_rsp.status != ST_OK, o_rsp.result_addr == '0, "failed transaction carries an address")
    `FLA_ASSERT_IMP(a_no_idle_write, ram_we, r_state != S_IDLE, "node table written while idle")
    `FLA_ASSERT_NXT(a_leave_idle, req_acc, r_state != S_IDLE, "accepted transaction did not start")

endmodule

// ===== dv/free_list_block_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Free list block allocator testbench
// Drives allocate and free transactions through the request channel, predicts
// every response with a behavioural model of the block table, and compares
// each response field by field. Fit policy is changed between phases.
// ----------------------------------------------------------------------------
module free_list_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fla_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        logic        cmd;
        logic [21:0] req_bytes;
        logic [21:0] free_addr;
        logic        has_exp;
        logic [21:0] exp_addr;
        logic [1:0]  exp_status;
    } t_row;

    typedef struct {
        logic [21:0] addr;
        logic [1:0]  status;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    fla_req_if req_ch();
    fla_rsp_if rsp_ch();
    fla_cfg_if cfg_ch();

    free_list_block_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // Model of the block table.
    int unsigned blk_offset [NODES];
    int unsigned blk_bytes  [NODES];
    bit          blk_used   [NODES];
    int unsigned blk_link   [NODES];
    bit          blk_valid  [NODES];
    int unsigned head_blk, tail_blk, rover_blk, arena_end;
    logic [1:0]  fit_mode;
    localparam int unsigned NONE = 32'hFFFF_FFFF;

    t_rsp        pending_rsp[$];
    int unsigned live_addr[$];
    bit          failed;
    int          stall_pct, gap_pct;
    bit          hold_rsp;
    longint      cycles;

    function automatic bit blk_ok(int unsigned i);
        return i < NODES && blk_valid[i];
    endfunction

    function automatic int unsigned scan_fit(int unsigned from, int unsigned stop,
                                             int unsigned need);
        int unsigned i;
        int unsigned n;
        i = from;
        n = 0;
        while (i != stop && blk_ok(i) && n < NODES) begin
            if (!blk_used[i] && blk_bytes[i] >= need) return i;
            i = blk_link[i];
            n++;
        end
        return NONE;
    endfunction

    function automatic int unsigned spare_blk();
        for (int unsigned i = 0; i < NODES; i++) if (!blk_valid[i]) return i;
        return NONE;
    endfunction

    function automatic t_rsp predict_alloc(int unsigned req);
        int unsigned need, b, i, n, slack, rest, steps;
        longint unsigned stop_at;
        t_rsp r;
        need = (req + 7) & ~32'd7;
        r.addr = '0;
        r.status = ST_OK;
        if (fit_mode == MODE_FIRST) begin
            b = scan_fit(head_blk, NONE, need);
        end else if (fit_mode == MODE_NEXT) begin
            b = scan_fit(rover_blk, NONE, need);
            if (b == NONE) b = scan_fit(head_blk, rover_blk, need);
            if (b != NONE) rover_blk = b;
        end else begin
            b = NONE;
            slack = 0;
            i = head_blk;
            steps = 0;
            while (blk_ok(i) && steps < NODES) begin
                if (!blk_used[i] && blk_bytes[i] >= need
                    && (b == NONE || blk_bytes[i] - need < slack)) begin
                    b = i;
                    slack = blk_bytes[i] - need;
                end
                i = blk_link[i];
                steps++;
            end
        end
        if (b != NONE) begin
            rest = blk_bytes[b] - need;
            if (rest >= 24) begin
                n = spare_blk();
                if (n != NONE) begin
                    blk_valid[n]  = 1;
                    blk_offset[n] = blk_offset[b] + 16 + need;
                    blk_bytes[n]  = rest - 16;
                    blk_used[n]   = 0;
                    blk_link[n]   = blk_link[b];
                    blk_link[b]   = n;
                    blk_bytes[b]  = need;
                    if (tail_blk == b) tail_blk = n;
                end
            end
            blk_used[b] = 1;
            r.addr = 22'(blk_offset[b] + 16);
            return r;
        end
        n = spare_blk();
        stop_at = longint'(arena_end) + need + 16;
        if (n == NONE || stop_at >= ARENA_BYTES) begin
            r.status = ST_NOSPACE;
            return r;
        end
        blk_valid[n]  = 1;
        blk_offset[n] = arena_end;
        blk_bytes[n]  = need;
        blk_used[n]   = 1;
        blk_link[n]   = NONE;
        arena_end     = int'(stop_at);
        if (head_blk == NONE) begin
            head_blk  = n;
            rover_blk = n;
        end
        if (blk_ok(tail_blk)) blk_link[tail_blk] = n;
        tail_blk = n;
        r.addr = 22'(blk_offset[n] + 16);
        return r;
    endfunction

    function automatic t_rsp predict_free(int unsigned addr);
        int unsigned i, steps, nx;
        t_rsp r;
        r.addr = '0;
        i = head_blk;
        steps = 0;
        while (blk_ok(i) && steps < NODES) begin
            if (blk_offset[i] + 16 == addr) break;
            i = blk_link[i];
            steps++;
        end
        if (!blk_ok(i) || steps >= NODES) begin
            r.status = ST_UNKNOWN;
            return r;
        end
        nx = blk_link[i];
        if (blk_ok(nx) && !blk_used[nx]) begin
            blk_bytes[i] = blk_bytes[i] + blk_bytes[nx] + 16;
            blk_link[i]  = blk_link[nx];
            blk_valid[nx] = 0;
            if (tail_blk == nx) tail_blk = i;
            if (rover_blk == nx) rover_blk = i;
        end
        blk_used[i] = 0;
        r.status = ST_OK;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Response side: ready driven at the falling edge, responses checked at the rising.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response addr %0d status %0d", $time,
                         rsp_ch.result_addr, rsp_ch.status);
                failed = 1;
            end else begin
                e = pending_rsp.pop_front();
                if (rsp_ch.result_addr !== e.addr) begin
                    $display("%0t: result_addr expected %0d actual %0d", $time,
                             e.addr, rsp_ch.result_addr);
                    failed = 1;
                end
                if (rsp_ch.status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             e.status, rsp_ch.status);
                    failed = 1;
                end
            end
        end
    end

    // Valid stays high between back-to-back transactions; it drops only in a gap
    // or when the sender drains.
    task automatic send_cmd(logic cmd, logic [21:0] bytes, logic [21:0] addr,
                            bit has_exp, logic [21:0] exp_addr, logic [1:0] exp_st);
        t_rsp p;
        while ($urandom_range(99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= cmd;
        req_ch.req_bytes <= bytes;
        req_ch.free_addr <= addr;
        do @(posedge i_clk); while (!req_ch.ready);
        if (cmd == CMD_ALLOC) p = predict_alloc(bytes);
        else p = predict_free(addr);
        if (has_exp && (p.addr !== exp_addr || p.status !== exp_st)) begin
            $display("%0t: table row expected addr %0d status %0d, predicted %0d %0d",
                     $time, exp_addr, exp_st, p.addr, p.status);
            failed = 1;
        end
        if (cmd == CMD_ALLOC && p.status == ST_OK) live_addr.push_back(p.addr);
        pending_rsp.push_back(p);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= m;
        do @(posedge i_clk); while (!cfg_ch.ready);
        fit_mode = (m == 2'd3) ? MODE_BEST : m;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_item();
        int k;
        logic [21:0] a;
        k = $urandom_range(99);
        if (k < 50) begin
            if ($urandom_range(19) == 0) a = 22'($urandom);
            else a = 22'($urandom_range(200));
            send_cmd(CMD_ALLOC, a, '0, 0, '0, ST_OK);
        end else if (k < 92 && live_addr.size() != 0) begin
            a = live_addr[$urandom_range(live_addr.size() - 1)];
            send_cmd(CMD_FREE, '0, a, 0, '0, ST_OK);
        end else begin
            send_cmd(CMD_FREE, '0, 22'($urandom), 0, '0, ST_OK);
        end
    endtask

    t_row table_rows[] = '{
        '{CMD_ALLOC, 22'd0,       '0,       1, 22'd16,  ST_OK},
        '{CMD_ALLOC, 22'd1,       '0,       1, 22'd32,  ST_OK},
        '{CMD_ALLOC, 22'd100,     '0,       1, 22'd56,  ST_OK},
        '{CMD_ALLOC, 22'h3FFFFF,  '0,       1, 22'd0,   ST_NOSPACE},
        '{CMD_FREE,  '0,          22'd0,    1, 22'd0,   ST_UNKNOWN},
        '{CMD_FREE,  '0,          22'h3FFFFF, 1, 22'd0, ST_UNKNOWN},
        '{CMD_FREE,  '0,          22'd56,   1, 22'd0,   ST_OK},
        '{CMD_FREE,  '0,          22'd56,   1, 22'd0,   ST_OK},
        '{CMD_ALLOC, 22'd8,       '0,       0, '0,      ST_OK},
        '{CMD_FREE,  '0,          22'd32,   0, '0,      ST_OK},
        '{CMD_FREE,  '0,          22'd16,   0, '0,      ST_OK},
        '{CMD_ALLOC, 22'd24,      '0,       0, '0,      ST_OK},
        '{CMD_ALLOC, 22'd40,      '0,       0, '0,      ST_OK},
        '{CMD_ALLOC, 22'h3FFFC0,  '0,       0, '0,      ST_OK},
        '{CMD_ALLOC, 22'd7,       '0,       0, '0,      ST_OK}
    };

    initial begin
        failed = 0;
        hold_rsp = 0;
        stall_pct = 0;
        gap_pct = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ALLOC;
        req_ch.req_bytes = '0;
        req_ch.free_addr = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = MODE_BEST;
        for (int i = 0; i < NODES; i++) begin
            blk_valid[i] = 0;
            blk_link[i] = NONE;
        end
        head_blk = NONE;
        tail_blk = NONE;
        rover_blk = NONE;
        arena_end = 0;
        fit_mode = MODE_BEST;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (table_rows[r])
            send_cmd(table_rows[r].cmd, table_rows[r].req_bytes, table_rows[r].free_addr,
                     table_rows[r].has_exp, table_rows[r].exp_addr,
                     table_rows[r].exp_status);

        // The sender waits here for every outstanding response.
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin stall_pct = 0;  gap_pct = 0;  end
                1: begin stall_pct = 0;  gap_pct = 81; end
                2: begin stall_pct = 81; gap_pct = 0;  end
                default: begin stall_pct = 13; gap_pct = 13; end
            endcase
            set_mode(logic'(ph == 7) ? 2'd3 : 2'(ph % 3));
            if (ph == 2) begin
                // Long hold-off on the response side so the request side backs up.
                fork
                    begin
                        hold_rsp = 1;
                        repeat (1500) @(negedge i_clk);
                        hold_rsp = 0;
                    end
                join_none
            end
            repeat (100) random_item();
        end

        drain();
        if (!failed) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
